/* hdl/tcip_pkg.sv */
`default_nettype none

package tcip_pkg;

   // One more than the longest line, terminator not counted, that is parsed in full.
   localparam int MAX_LINE = 4096;
   localparam int OFFSET_W = $clog2(MAX_LINE);
   localparam logic [OFFSET_W-1:0] OFFSET_LAST = OFFSET_W'(MAX_LINE - 1);

   // Fixed field widths of the channels.
   localparam int CH_W     = 8;
   localparam int COL_W    = 4;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 12;
   localparam int STATUS_W = 2;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_COMMENT = 2'd0;
   localparam logic [STATUS_W-1:0] ST_PARSED  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ERROR   = 2'd2;

   // Register indexes of the configuration port.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_NAME_COLUMN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_COLUMN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_END_COLUMN   = 2'd2;

   // Byte codes the parser reacts to.
   localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CH_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CH_W-1:0] CH_VT    = 8'h0B;
   localparam logic [CH_W-1:0] CH_FF    = 8'h0C;
   localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CH_W-1:0] CH_HASH  = 8'h23;
   localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

   typedef struct packed {
      logic [COL_W-1:0] name_column;
      logic [COL_W-1:0] start_column;
      logic [COL_W-1:0] end_column;
   } cfg_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] start_value;
      logic signed [VALUE_W-1:0] end_value;
      logic [POS_W-1:0]          name_begin;
      logic [POS_W-1:0]          name_end;
   } result_type;

endpackage

`default_nettype wire

/* hdl/tcip_if.sv */
`default_nettype none

interface tcip_req_if;
   import tcip_pkg::*;

   logic            valid;
   logic            ready;
   logic [CH_W-1:0] ch;

   modport source (output valid, output ch, input ready);
   modport sink (input valid, input ch, output ready);
endinterface

interface tcip_rsp_if;
   import tcip_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic signed [VALUE_W-1:0] start_value;
   logic signed [VALUE_W-1:0] end_value;
   logic [POS_W-1:0]          name_begin;
   logic [POS_W-1:0]          name_end;

   modport source (output valid, output status, output start_value, output end_value,
                   output name_begin, output name_end, input ready);
   modport sink (input valid, input status, input start_value, input end_value,
                 input name_begin, input name_end, output ready);
endinterface

`default_nettype wire

/* hdl/tsv_column_integer_parser.sv */
`default_nettype none

// Channel  Dir  Handshake      Payload
// req_bus  in   valid/ready    ch: one line byte, zero ends the line
// rsp_bus  out  valid/ready    status, start_value, end_value, name_begin, name_end
// csr_*    in   write enable   csr_index selects the register, csr_wdata is its value
//
// One byte is taken in every cycle. A byte is held in the input register and updates
// the line state as it leaves it; a terminator that leaves it loads the result of its
// line into the result register, which offers it on rsp_bus. Reset is synchronous and
// restores the default column layout (name 0, start 1, end 2) and an empty line. Only
// a terminator can stall: it waits in the input register, holding back the bytes
// behind it, while the result register is full and not being drained.

module tsv_column_integer_parser (
   input  wire logic                           clock,
   input  wire logic                           reset,
   tcip_req_if.sink                            req_bus,
   tcip_rsp_if.source                          rsp_bus,
   input  wire logic                           csr_write_en,
   input  wire logic [tcip_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [tcip_pkg::COL_W-1:0]     csr_wdata
);
   import tcip_pkg::*;

   cfg_type    cfg;
   result_type line_result;

   logic            in_valid_ff, in_valid_in;
   logic [CH_W-1:0] in_ch_ff;
   logic            out_valid_ff, out_valid_in;
   result_type      out_data_ff;

   logic req_transfer;
   logic slot_free;
   logic advance;
   logic is_term;

   tcip_csr_regs u_csr_regs (
      .clock    (clock),
      .reset    (reset),
      .write_en (csr_write_en),
      .index    (csr_index),
      .wdata    (csr_wdata),
      .cfg      (cfg)
   );

   tcip_line_state u_line_state (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .ch      (in_ch_ff),
      .cfg     (cfg),
      .result  (line_result)
   );

   // The held byte moves on unless it is a terminator whose result has nowhere to go.
   assign is_term      = (in_ch_ff == CH_NUL);
   assign slot_free    = !out_valid_ff || rsp_bus.ready;
   assign advance      = in_valid_ff && (!is_term || slot_free);
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_transfer = req_bus.valid && req_bus.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_transfer) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance && is_term) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_transfer) begin
         in_ch_ff <= req_bus.ch;
      end
      if (advance && is_term) begin
         out_data_ff <= line_result;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.status      = out_data_ff.status;
   assign rsp_bus.start_value = out_data_ff.start_value;
   assign rsp_bus.end_value   = out_data_ff.end_value;
   assign rsp_bus.name_begin  = out_data_ff.name_begin;
   assign rsp_bus.name_end    = out_data_ff.name_end;

endmodule

`default_nettype wire

/* hdl/tcip_csr_regs.sv */
`default_nettype none

module tcip_csr_regs (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           write_en,
   input  wire logic [tcip_pkg::CSR_IDX_W-1:0] index,
   input  wire logic [tcip_pkg::COL_W-1:0]     wdata,
   output tcip_pkg::cfg_type                   cfg
);
   import tcip_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            CSR_NAME_COLUMN:  cfg_in.name_column  = wdata;
            CSR_START_COLUMN: cfg_in.start_column = wdata;
            CSR_END_COLUMN:   cfg_in.end_column   = wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.name_column  <= COL_W'(0);
         cfg_ff.start_column <= COL_W'(1);
         cfg_ff.end_column   <= COL_W'(2);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* hdl/tcip_line_state.sv */
`default_nettype none

module tcip_line_state (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      step_en,
   input  wire logic [tcip_pkg::CH_W-1:0] ch,
   input  wire tcip_pkg::cfg_type         cfg,
   output tcip_pkg::result_type           result
);
   import tcip_pkg::*;

   localparam int CIDX_W = COL_W + 1;
   localparam logic [1:0] PH_LEAD   = 2'd0;
   localparam logic [1:0] PH_SIGN   = 2'd1;
   localparam logic [1:0] PH_DIGITS = 2'd2;
   localparam logic [1:0] PH_DONE   = 2'd3;
   localparam logic [CIDX_W-1:0] CIDX_MAX = '1;

   logic [CIDX_W-1:0]         col_ff, col_in;
   logic [OFFSET_W-1:0]       off_ff, off_in;
   logic [1:0]                phase_ff, phase_in;
   logic                      neg_ff, neg_in;
   logic signed [VALUE_W-1:0] start_acc_ff, start_acc_in;
   logic signed [VALUE_W-1:0] end_acc_ff, end_acc_in;
   logic [1:0]                digits_ff, digits_in;
   logic [OFFSET_W-1:0]       nbeg_ff, nbeg_in;
   logic [OFFSET_W-1:0]       nend_ff, nend_in;
   logic                      comment_ff, comment_in;
   logic                      ovf_ff, ovf_in;

   logic [CIDX_W-1:0] name_col, start_col, end_col, col_inc;
   logic              is_digit, is_space, is_sign, to_start, to_end, line_ok;
   logic [OFFSET_W-1:0] name_end_out;

   // Multiply by ten and add or subtract one digit, clamped to 32 bits.
   function automatic logic signed [VALUE_W-1:0] push_digit(
      input logic signed [VALUE_W-1:0] acc,
      input logic [3:0]                d,
      input logic                      neg
   );
      logic signed [VALUE_W+4:0] wide;
      logic signed [VALUE_W+4:0] dx;
      wide = {{5{acc[VALUE_W-1]}}, acc};
      wide = (wide <<< 3) + (wide <<< 1);
      dx = {{(VALUE_W+1){1'b0}}, d};
      wide = neg ? wide - dx : wide + dx;
      if (wide > 37'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (wide < -37'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return $signed(wide[VALUE_W-1:0]);
   endfunction

   // Offsets are reported in the low bits of the result field.
   function automatic logic [POS_W-1:0] to_pos(input logic [OFFSET_W-1:0] off);
      logic [OFFSET_W+POS_W-1:0] ext;
      ext = {{POS_W{1'b0}}, off};
      return ext[POS_W-1:0];
   endfunction

   assign name_col  = {1'b0, cfg.name_column};
   assign start_col = {1'b0, cfg.start_column};
   assign end_col   = {1'b0, cfg.end_column};
   assign col_inc   = (col_ff == CIDX_MAX) ? col_ff : col_ff + 1'b1;

   assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign is_space = (ch == CH_SPACE) || (ch == CH_LF) || (ch == CH_VT) ||
                     (ch == CH_FF) || (ch == CH_CR);
   assign is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
   assign to_start = (col_ff == start_col);
   assign to_end   = (col_ff == end_col);

   always_comb begin
      col_in       = col_ff;
      off_in       = off_ff;
      phase_in     = phase_ff;
      neg_in       = neg_ff;
      start_acc_in = start_acc_ff;
      end_acc_in   = end_acc_ff;
      digits_in    = digits_ff;
      nbeg_in      = nbeg_ff;
      nend_in      = nend_ff;
      comment_in   = comment_ff;
      ovf_in       = ovf_ff;
      if (ch == CH_NUL) begin
         col_in       = '0;
         off_in       = '0;
         phase_in     = PH_LEAD;
         neg_in       = 1'b0;
         start_acc_in = '0;
         end_acc_in   = '0;
         digits_in    = '0;
         nbeg_in      = '0;
         nend_in      = '0;
         comment_in   = 1'b0;
         ovf_in       = 1'b0;
      end else if (comment_ff || ovf_ff) begin
         // The rest of the line is ignored.
      end else if ((off_ff == '0) && (ch == CH_HASH)) begin
         comment_in = 1'b1;
      end else if (off_ff >= OFFSET_LAST) begin
         ovf_in = 1'b1;
      end else begin
         off_in = off_ff + 1'b1;
         if (ch == CH_TAB) begin
            if (col_ff == name_col) begin
               nend_in = off_ff;
            end
            col_in = col_inc;
            if (col_inc == name_col) begin
               nbeg_in = off_ff + 1'b1;
            end
            phase_in = PH_LEAD;
            neg_in   = 1'b0;
         end else if (to_start || to_end) begin
            if ((phase_ff == PH_LEAD) && is_space) begin
               // Leading white space is skipped.
            end else if ((phase_ff == PH_LEAD) && is_sign) begin
               neg_in   = (ch == CH_MINUS);
               phase_in = PH_SIGN;
            end else if (phase_ff == PH_DONE) begin
               // Trailing bytes of the column are ignored.
            end else if (!is_digit) begin
               phase_in = PH_DONE;
            end else begin
               phase_in = PH_DIGITS;
               if (to_start) begin
                  start_acc_in = push_digit(start_acc_ff, ch[3:0], neg_ff);
                  digits_in[0] = 1'b1;
               end
               if (to_end) begin
                  end_acc_in   = push_digit(end_acc_ff, ch[3:0], neg_ff);
                  digits_in[1] = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         off_ff       <= '0;
         phase_ff     <= PH_LEAD;
         neg_ff       <= 1'b0;
         start_acc_ff <= '0;
         end_acc_ff   <= '0;
         digits_ff    <= '0;
         nbeg_ff      <= '0;
         nend_ff      <= '0;
         comment_ff   <= 1'b0;
         ovf_ff       <= 1'b0;
      end else if (step_en) begin
         col_ff       <= col_in;
         off_ff       <= off_in;
         phase_ff     <= phase_in;
         neg_ff       <= neg_in;
         start_acc_ff <= start_acc_in;
         end_acc_ff   <= end_acc_in;
         digits_ff    <= digits_in;
         nbeg_ff      <= nbeg_in;
         nend_ff      <= nend_in;
         comment_ff   <= comment_in;
         ovf_ff       <= ovf_in;
      end
   end

   // Result of the line, valid when the current byte is the terminator.
   assign line_ok = !ovf_ff && (off_ff != '0) && (col_ff >= start_col) &&
                    (col_ff >= end_col) && (col_ff >= name_col) && (digits_ff == 2'b11);
   assign name_end_out = (col_ff == name_col) ? off_ff : nend_ff;

   always_comb begin
      result = '0;
      if (comment_ff) begin
         result.status = ST_COMMENT;
      end else if (line_ok) begin
         result.status      = ST_PARSED;
         result.start_value = start_acc_ff;
         result.end_value   = end_acc_ff;
         result.name_begin  = to_pos(nbeg_ff);
         result.name_end    = to_pos(name_end_out);
      end else begin
         result.status = ST_ERROR;
      end
   end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import tcip_pkg::*;

   // Upper bound on the run; the slowest legal run is several times shorter.
   localparam int CYCLE_LIMIT    = 1000000;
   // Cycles allowed after the last result of a phase before the layout changes.
   localparam int SETTLE_CYCLES  = 4;
   // The receiver parks itself now and then; HOLDOFF_PERIOD sets how often, HOLDOFF_LEN how long.
   localparam int HOLDOFF_PERIOD = 500;
   localparam int HOLDOFF_LEN    = 120;

   localparam longint VALUE_MAX = 64'sd2147483647;
   localparam longint VALUE_MIN = -64'sd2147483648;

   // Where the number scanner stands inside the current start or end column.
   typedef enum logic [1:0] {
      NUM_LEAD,
      NUM_SIGN,
      NUM_DIGITS,
      NUM_DONE
   } number_phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index    = CSR_NAME_COLUMN;
   logic [COL_W-1:0]     csr_wdata    = '0;

   tcip_req_if req_bus ();
   tcip_rsp_if rsp_bus ();

   tsv_column_integer_parser u_top (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .rsp_bus      (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The column layout as the parser should currently hold it. It only changes while
   // the parser is idle, so the driver can read it without care.
   logic [COL_W-1:0] layout_name  = 4'd0;
   logic [COL_W-1:0] layout_start = 4'd1;
   logic [COL_W-1:0] layout_end   = 4'd2;

   // Shadow copy of the per-line parser state.
   int unsigned      col_idx;
   int unsigned      line_pos;
   number_phase_type num_phase;
   bit               num_negative;
   logic signed [VALUE_W-1:0] start_acc;
   logic signed [VALUE_W-1:0] end_acc;
   bit            start_seen;
   bit            end_seen;
   int unsigned   name_from;
   int unsigned   name_to;
   bit            in_comment;
   bit            too_long;

   // Bytes waiting to be offered, the line under construction, and line results the parser still owes us.
   logic [CH_W-1:0] line_bytes_queued[$];
   logic [CH_W-1:0] line_build[$];
   result_type      results_due[$];

   int  cycle_count   = 0;
   int  mismatch_count = 0;
   int  bytes_sent    = 0;
   int  lines_parsed  = 0;
   int  lines_comment = 0;
   int  lines_error   = 0;
   int  layouts_run   = 0;

   // Sender burst state, receiver pattern state and the long hold-off.
   int  burst_left;
   int  gap_left;
   int  pattern_left;
   int  ready_pct;
   int  holdoff_timer;
   int  holdoff_left;
   logic receiver_parked;
   result_type want;

   function automatic void clear_line_state();
      col_idx      = 0;
      line_pos     = 0;
      num_phase    = NUM_LEAD;
      num_negative = 1'b0;
      start_acc    = '0;
      end_acc      = '0;
      start_seen   = 1'b0;
      end_seen     = 1'b0;
      name_from    = 0;
      name_to      = 0;
      in_comment   = 1'b0;
      too_long     = 1'b0;
   endfunction

   // Appends one decimal digit to a running value, sticking at the 32-bit bounds.
   // The sign decides whether the digit is added or taken away.
   function automatic logic signed [VALUE_W-1:0] shift_in_digit(
      logic signed [VALUE_W-1:0] acc, int digit, bit negative);
      longint v;
      v = longint'(acc) * 10;
      v = negative ? v - longint'(digit) : v + longint'(digit);
      if (v > VALUE_MAX) v = VALUE_MAX;
      if (v < VALUE_MIN) v = VALUE_MIN;
      return v[VALUE_W-1:0];
   endfunction

   // Advances the shadow line state by one transferred byte. A terminator closes the
   // line: the result it must produce is queued and the line state starts over.
   function automatic void track_line_byte(logic [CH_W-1:0] ch);
      result_type r;
      bit to_start, to_end, is_digit, lead_blank, lead_sign;
      if (ch == CH_NUL) begin
         r = '0;
         r.status = ST_ERROR;
         if (in_comment) begin
            r.status = ST_COMMENT;
         end else if (!too_long && line_pos > 0 && col_idx >= layout_start &&
                      col_idx >= layout_end && col_idx >= layout_name &&
                      start_seen && end_seen) begin
            r.status      = ST_PARSED;
            r.start_value = start_acc;
            r.end_value   = end_acc;
            r.name_begin  = POS_W'(name_from);
            // A name column that is still open ends at the terminator itself.
            r.name_end    = (col_idx == layout_name) ? POS_W'(line_pos) : POS_W'(name_to);
         end
         results_due.insert(results_due.size(), r);
         clear_line_state();
         return;
      end
      if (in_comment || too_long) return;
      if (line_pos == 0 && ch == CH_HASH) begin
         in_comment = 1'b1;
         return;
      end
      // Past the longest line the parser gives up and only waits for the terminator.
      if (line_pos >= OFFSET_LAST) begin
         too_long = 1'b1;
         return;
      end
      if (ch == CH_TAB) begin
         if (col_idx == layout_name) name_to = line_pos;
         if (col_idx < 31) col_idx++;
         if (col_idx == layout_name) name_from = line_pos + 1;
         num_phase    = NUM_LEAD;
         num_negative = 1'b0;
      end else begin
         to_start = (col_idx == layout_start);
         to_end   = (col_idx == layout_end);
         if (to_start || to_end) begin
            is_digit   = (ch >= CH_ZERO && ch <= CH_NINE);
            lead_blank = (num_phase == NUM_LEAD) &&
                         (ch == CH_SPACE || ch == CH_LF || ch == CH_VT ||
                          ch == CH_FF || ch == CH_CR);
            lead_sign  = (num_phase == NUM_LEAD) && (ch == CH_PLUS || ch == CH_MINUS);
            if (lead_sign) begin
               num_negative = (ch == CH_MINUS);
               num_phase    = NUM_SIGN;
            end else if (!lead_blank && num_phase != NUM_DONE) begin
               if (!is_digit) begin
                  // The first non-digit ends the number; the rest of the column is ignored.
                  num_phase = NUM_DONE;
               end else begin
                  num_phase = NUM_DIGITS;
                  if (to_start) begin
                     start_acc  = shift_in_digit(start_acc, int'(ch - CH_ZERO), num_negative);
                     start_seen = 1'b1;
                  end
                  if (to_end) begin
                     end_acc  = shift_in_digit(end_acc, int'(ch - CH_ZERO), num_negative);
                     end_seen = 1'b1;
                  end
               end
            end
         end
      end
      line_pos++;
   endfunction

   // Any byte that may sit inside a column: never a terminator, never a tab.
   // Mostly printable text, sometimes any other code up to 255.
   function automatic logic [CH_W-1:0] random_field_byte();
      logic [CH_W-1:0] b;
      if ($urandom_range(0, 2) != 0) begin
         b = CH_W'($urandom_range(33, 126));
      end else begin
         b = CH_W'($urandom_range(1, 254));
         if (b >= CH_TAB) b = b + 1'b1;
      end
      return b;
   endfunction

   // Adds one byte to the end of the line under construction.
   function automatic void add_build_byte(logic [CH_W-1:0] b);
      line_build.insert(line_build.size(), b);
   endfunction

   function automatic void append_text(string s);
      for (int i = 0; i < s.len(); i++) add_build_byte(CH_W'(s[i]));
   endfunction

   // Moves the line under construction to the send queue and closes it with a terminator.
   function automatic void flush_line();
      foreach (line_build[i]) line_bytes_queued.insert(line_bytes_queued.size(), line_build[i]);
      line_bytes_queued.insert(line_bytes_queued.size(), CH_NUL);
      line_build.delete();
   endfunction

   function automatic void queue_line(string s);
      append_text(s);
      flush_line();
   endfunction

   // One number column: optional leading blanks, optional sign, digits of varied
   // length (values near and beyond the 32-bit bounds among them), and optional junk
   // after the digits. A broken column leaves out the digits; only its junk may hold any.
   function automatic void append_number(bit broken);
      int style;
      logic [CH_W-1:0] b;
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 4))
               0: b = CH_SPACE;
               1: b = CH_LF;
               2: b = CH_VT;
               3: b = CH_FF;
               default: b = CH_CR;
            endcase
            add_build_byte(b);
         end
      end
      style = $urandom_range(0, 2);
      if (style == 0) add_build_byte(CH_PLUS);
      if (style == 1) add_build_byte(CH_MINUS);
      if (!broken) begin
         style = $urandom_range(0, 19);
         if (style < 3) begin
            case ($urandom_range(0, 3))
               0: append_text("2147483647");
               1: append_text("2147483648");
               2: append_text("0002147483647");
               default: append_text("99999999999");
            endcase
         end else begin
            repeat ((style < 12) ? $urandom_range(1, 4) :
                    (style < 16) ? $urandom_range(5, 9) : $urandom_range(10, 14))
               add_build_byte(CH_W'(CH_ZERO + $urandom_range(0, 9)));
         end
      end
      if ($urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 4)) add_build_byte(random_field_byte());
   endfunction

   // Builds one random line for the current layout. Most lines are well formed with
   // random content; the rest are comments, raw noise, lines short of columns and
   // lines with extra columns.
   function automatic void build_random_line();
      int kind, ncols, top;
      top = layout_name;
      if (layout_start > top) top = layout_start;
      if (layout_end > top) top = layout_end;
      kind = $urandom_range(0, 99);
      if (kind < 7) begin
         add_build_byte(CH_HASH);
         repeat ($urandom_range(0, 20)) add_build_byte(CH_W'($urandom_range(1, 255)));
      end else if (kind < 14) begin
         repeat ($urandom_range(0, 30)) add_build_byte(CH_W'($urandom_range(1, 255)));
      end else begin
         ncols = top + 1;
         if (kind < 24) ncols = $urandom_range(0, top);
         else if (kind < 38) ncols += $urandom_range(1, 3);
         for (int c = 0; c < ncols; c++) begin
            if (c != 0) add_build_byte(CH_TAB);
            if (c == layout_start || c == layout_end)
               append_number($urandom_range(0, 15) == 0);
            else
               repeat ($urandom_range(0, (c == layout_name) ? 8 : 3))
                  add_build_byte(random_field_byte());
         end
      end
   endfunction

   // Queues random lines until both the byte and the line budget are spent, so that
   // every layout, wide lines or not, still produces a number of results.
   function automatic void queue_random_lines(int min_bytes, int min_lines);
      int bytes_made, lines_made;
      bytes_made = 0;
      lines_made = 0;
      while (bytes_made < min_bytes || lines_made < min_lines) begin
         build_random_line();
         bytes_made += line_build.size() + 1;
         lines_made++;
         flush_line();
      end
   endfunction

   // Waits until every queued byte has been transferred and every owed result has
   // arrived, then lets the pipeline settle.
   task automatic drain_parser();
      while (line_bytes_queued.size() != 0 || req_bus.valid || results_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the name, start and end column registers in turn. Called only while idle.
   task automatic load_layout(logic [COL_W-1:0] name_col, logic [COL_W-1:0] start_col,
                              logic [COL_W-1:0] end_col);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_NAME_COLUMN;
      csr_wdata    <= name_col;
      @(posedge clock);
      csr_index    <= CSR_START_COLUMN;
      csr_wdata    <= start_col;
      @(posedge clock);
      csr_index    <= CSR_END_COLUMN;
      csr_wdata    <= end_col;
      @(posedge clock);
      csr_write_en <= 1'b0;
      layout_name  = name_col;
      layout_start = start_col;
      layout_end   = end_col;
      layouts_run++;
   endtask

   function automatic void check_field(string field, longint expected, longint actual);
      if (expected != actual) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                  $time, field, expected, actual);
         mismatch_count++;
      end
   endfunction

   // Driver. A byte is held on the bus until it is transferred. The sender works in
   // bursts of random length separated by random gaps, and some bursts run to 400
   // bytes.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.ch    <= CH_NUL;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            track_line_byte(req_bus.ch);
            bytes_sent++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (line_bytes_queued.size() != 0) begin
               req_bus.valid <= 1'b1;
               req_bus.ch    <= line_bytes_queued.pop_front();
               if (burst_left <= 1) begin
                  burst_left = ($urandom_range(0, 19) == 0) ? 400 : $urandom_range(1, 48);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Periodic hold-off. While the receiver is parked the sender keeps offering bytes,
   // so the result register fills and the next terminator is held in the input register.
   always @(posedge clock) begin
      if (reset) begin
         holdoff_timer = 0;
         holdoff_left  = 0;
         receiver_parked <= 1'b0;
      end else begin
         holdoff_timer++;
         if (holdoff_left != 0) begin
            holdoff_left--;
            if (holdoff_left == 0) receiver_parked <= 1'b0;
         end else if (holdoff_timer % HOLDOFF_PERIOD == 0) begin
            holdoff_left = HOLDOFF_LEN;
            receiver_parked <= 1'b1;
         end
      end
   end

   // Monitor. Every transferred result is checked field by field against the oldest
   // owed result. The receiver's ready follows windows of random length, each with its
   // own acceptance rate; a rate of 100 gives stretches without any stall unless parked.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         pattern_left = 0;
         ready_pct    = 100;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (results_due.size() == 0) begin
               $display("%0t ns: unexpected result, expected none, actual status %0d",
                        $time, rsp_bus.status);
               mismatch_count++;
            end else begin
               want = results_due.pop_front();
               check_field("status", longint'(want.status), longint'(rsp_bus.status));
               check_field("start_value", longint'($signed(want.start_value)),
                           longint'($signed(rsp_bus.start_value)));
               check_field("end_value", longint'($signed(want.end_value)),
                           longint'($signed(rsp_bus.end_value)));
               check_field("name_begin", longint'(want.name_begin),
                           longint'(rsp_bus.name_begin));
               check_field("name_end", longint'(want.name_end), longint'(rsp_bus.name_end));
               if (want.status == ST_PARSED) lines_parsed++;
               else if (want.status == ST_COMMENT) lines_comment++;
               else lines_error++;
            end
         end
         if (pattern_left == 0) begin
            pattern_left = $urandom_range(16, 200);
            case ($urandom_range(0, 3))
               0: ready_pct = 100;
               1: ready_pct = 85;
               2: ready_pct = 50;
               default: ready_pct = 20;
            endcase
         end else begin
            pattern_left--;
         end
         rsp_bus.ready <= !receiver_parked && ($urandom_range(0, 99) < ready_pct);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles: %0d bytes queued, %0d results owed.",
                  cycle_count, line_bytes_queued.size(), results_due.size());
         $display("tsv_column_integer_parser regression: fail");
         $finish;
      end
   end

   // Stimulus sequence. Each phase loads a column layout, queues its directed lines, if any,
   // and its random lines, and drains the parser before the next layout is loaded.
   initial begin
      req_bus.valid = 1'b0;
      req_bus.ch    = CH_NUL;
      rsp_bus.ready = 1'b0;
      clear_line_state();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Default layout: name, start, end in the first three columns.
      load_layout(4'd0, 4'd1, 4'd2);
      queue_line("chr1\t100\t200");
      queue_line("#comment\t1\t2");
      queue_line("#");
      queue_line("");
      queue_line("chr1\t100");
      queue_line("chr1\t\t200");
      queue_line("x\t  -5\t+7xyz");
      queue_line("x\t2147483647\t-2147483648");
      queue_line("x\t99999999999\t-99999999999");
      // A line that opens with a tab has an empty first column.
      queue_line("\t1\t2");
      queue_line("x\t\013\014\015\012 12\t 3 4");
      queue_line("x\t+-5\t3");
      queue_line("x\t- 5\t3");
      queue_line("x\t1\t2\textra\tmore");
      // A hash that is not the first byte does not make a comment.
      queue_line(" #x\t1\t2");
      queue_line("\377\200\t0\t-0");
      // More tabs than the column counter can count.
      append_text("x\t1\t2");
      repeat (40) add_build_byte(CH_TAB);
      flush_line();
      queue_random_lines(120, 10);
      drain_parser();

      // Start and end share one column.
      load_layout(4'd0, 4'd1, 4'd1);
      queue_line("a\t-42\tq");
      queue_line("a\t\tq");
      queue_random_lines(120, 10);
      drain_parser();

      // End comes before start, and the name column is last, so it runs to the
      // terminator.
      load_layout(4'd3, 4'd2, 4'd1);
      queue_line("9\t-8\t7\tname");
      queue_line("z\t1\t2");
      queue_random_lines(120, 10);
      drain_parser();

      // Highest column for every register.
      load_layout(4'd15, 4'd15, 4'd15);
      repeat (15) add_build_byte(CH_TAB);
      append_text("5");
      flush_line();
      repeat (14) add_build_byte(CH_TAB);
      append_text("5");
      flush_line();
      queue_random_lines(120, 10);
      drain_parser();

      // Lowest column for every register: one column is name and both numbers.
      load_layout(4'd0, 4'd0, 4'd0);
      queue_line("  -17xyz");
      queue_line("\t3");
      queue_line("+00042");
      queue_random_lines(120, 10);
      drain_parser();

      repeat (2) begin
         load_layout(COL_W'($urandom_range(0, 15)), COL_W'($urandom_range(0, 15)),
                     COL_W'($urandom_range(0, 15)));
         queue_random_lines(120, 10);
         drain_parser();
      end

      $display("Covered %0d bytes in %0d column layouts, with bursty input and stalled output.",
               bytes_sent, layouts_run);
      $display("Lines checked: %0d parsed, %0d comment, %0d error; %0d mismatches.",
               lines_parsed, lines_comment, lines_error, mismatch_count);
      if (mismatch_count == 0 && results_due.size() == 0) begin
         $display("tsv_column_integer_parser regression: pass");
      end else begin
         $display("tsv_column_integer_parser regression: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* files.f */
hdl/tcip_pkg.sv
hdl/tcip_if.sv
hdl/tcip_csr_regs.sv
hdl/tcip_line_state.sv
hdl/tsv_column_integer_parser.sv
tb/tb_top.sv
